>>> rtl/mfa_pkg.sv
package mfa_pkg;

  // Fixed number format of every weight, feature, hidden value and score.
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = VALUE_BITS - 4;
  localparam int SLOT_BITS  = 8;
  localparam int INDEX_BITS = 2;

  // Exact products, and an accumulator wide enough for 64 of them.
  // The wider clamp of the arithmetic can never be reached at this width.
  localparam int PROD_BITS = 2 * VALUE_BITS;
  localparam int ACC_BITS  = PROD_BITS + 7;

  // Command fields are sized for the largest supported network.
  localparam int ADDR_BITS = 12;
  localparam int UNIT_BITS = 6;
  localparam int TERM_BITS = 6;

  // Cycles between the last product of a layer and the first use of its results.
  localparam int DRAIN_CYCLES = 6;
  localparam int DRAIN_BITS   = 3;

  localparam longint unsigned ONE30 = 64'd1 << 30;

  typedef longint unsigned u64_t;

  typedef enum logic {
    OP_WEIGHT  = 1'b0,
    OP_FEATURE = 1'b1
  } op_t;

  typedef enum logic {
    LAYER_HIDDEN = 1'b0,
    LAYER_OUTPUT = 1'b1
  } layer_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIDDEN,
    ST_HDRAIN,
    ST_OUTPUT,
    ST_ODRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                          op;
    logic [SLOT_BITS-1:0]         slot;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        best_index;
    logic signed [VALUE_BITS-1:0] best_score;
  } out_item_t;

  // Controller to datapath: one multiply-accumulate term per cycle plus
  // the input transfer and result load strobes.
  typedef struct packed {
    logic                 accept;
    logic                 load;
    logic                 issue;
    logic                 first;
    logic                 last;
    layer_t               layer;
    logic [ADDR_BITS-1:0] waddr;
    logic [TERM_BITS-1:0] oidx;
    logic [UNIT_BITS-1:0] unit;
  } cmd_t;

  // Tag that travels with each term down the datapath pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last;
    layer_t               layer;
    logic [UNIT_BITS-1:0] unit;
  } tag_t;

  // Restoring division, used only while building the tanh table.
  function automatic longint unsigned mfa_udiv(input longint unsigned n,
                                               input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One tanh table entry: tanh at the lower edge of the bin, in fixed point.
  // e^-2a is built as (e^-(2a/32))^32 from a short Taylor series.
  function automatic logic signed [VALUE_BITS-1:0] tanh_entry(input longint unsigned idx,
                                                               input int tb);
    longint unsigned xo;
    longint unsigned a;
    longint unsigned z;
    longint unsigned term;
    longint unsigned ue;
    longint unsigned num;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned half;
    longint          e;
    logic            neg;
    half = 64'd1 << (VALUE_BITS - 1);
    xo   = (idx << VALUE_BITS) >> tb;
    neg  = xo < half;
    a    = neg ? half - xo : xo - half;
    z    = (a << (31 - FRAC_BITS)) >> 5;
    term = ONE30;
    e    = longint'(ONE30);
    // Terms shrink to zero well before the last step for z up to one half.
    for (int k = 1; k < 20; k++) begin
      term = mfa_udiv((term * z) >> 30, u64_t'(k));
      if (k[0]) begin
        e = e - longint'(term);
      end else begin
        e = e + longint'(term);
      end
    end
    ue = u64_t'(e);
    for (int i = 0; i < 5; i++) begin
      ue = (ue * ue) >> 30;
    end
    num = ONE30 - ue;
    den = ONE30 + ue;
    mag = mfa_udiv((num << FRAC_BITS) + (den >> 1), den);
    return neg ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
  endfunction

endpackage

>>> rtl/mfa_tanh_rom.sv
module mfa_tanh_rom #(
  parameter int TANH_ENTRIES = 1024
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [$clog2(TANH_ENTRIES)-1:0]        addr,
  output logic signed [mfa_pkg::VALUE_BITS-1:0]  rd_data
);
  import mfa_pkg::*;

  localparam int TB = $clog2(TANH_ENTRIES);

  typedef logic signed [VALUE_BITS-1:0] rom_t [TANH_ENTRIES];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      r[i] = tanh_entry(u64_t'(i), TB);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic signed [VALUE_BITS-1:0] rd_data_r;

  // Constant table with a registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mfa_datapath.sv
module mfa_datapath #(
  parameter int FEAT_COUNT   = 9,
  parameter int HID_COUNT    = 18,
  parameter int OUT_COUNT    = 3,
  parameter int TANH_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfa_pkg::cmd_t       cmd,
  input  mfa_pkg::in_item_t   in_data,
  output mfa_pkg::out_item_t  out_data
);
  import mfa_pkg::*;

  localparam int WGT_TOTAL = FEAT_COUNT * HID_COUNT + HID_COUNT * OUT_COUNT;
  localparam int WAW = (WGT_TOTAL > 1) ? $clog2(WGT_TOTAL) : 1;
  localparam int IAW = (FEAT_COUNT > 1) ? $clog2(FEAT_COUNT) : 1;
  localparam int HAW = (HID_COUNT > 1) ? $clog2(HID_COUNT) : 1;
  localparam int TB  = $clog2(TANH_ENTRIES);

  localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(-(64'sd1 <<< (VALUE_BITS - 1)));

  // Storage.
  logic signed [VALUE_BITS-1:0] wmem   [WGT_TOTAL];
  logic signed [VALUE_BITS-1:0] feat_r [FEAT_COUNT];
  logic signed [VALUE_BITS-1:0] hmem   [HID_COUNT];

  // Pipeline registers.
  tag_t                         tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  tag_t                         tag1_nxt, tag3_nxt, tag5_nxt;
  logic signed [VALUE_BITS-1:0] w_r;
  logic signed [VALUE_BITS-1:0] fx_r;
  logic signed [VALUE_BITS-1:0] hx_r;
  logic signed [VALUE_BITS-1:0] opnd;
  logic signed [PROD_BITS-1:0]  prod_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic signed [ACC_BITS-1:0]   shifted;
  logic signed [VALUE_BITS-1:0] sat_nxt;
  logic signed [VALUE_BITS-1:0] sat_r;
  logic [VALUE_BITS+TB-1:0]     rom_idx;
  logic [TB-1:0]                rom_addr;
  logic                         rom_en;
  logic signed [VALUE_BITS-1:0] tanh_q;
  logic signed [VALUE_BITS-1:0] best_score_r;
  logic [INDEX_BITS-1:0]        best_index_r;
  out_item_t                    out_q_r;

  logic wr_weight;
  logic wr_feature;

  assign wr_weight  = cmd.accept && (in_data.op == OP_WEIGHT) &&
                      (32'(in_data.slot) < WGT_TOTAL);
  assign wr_feature = cmd.accept && (in_data.op == OP_FEATURE) &&
                      (32'(in_data.slot) < FEAT_COUNT);

  // Weight store: one write port for loads, one registered read port for the pass.
  always_ff @(posedge clk) begin
    if (wr_weight) begin
      wmem[WAW'(in_data.slot)] <= in_data.value;
    end
    w_r <= wmem[cmd.waddr[WAW-1:0]];
  end

  // Feature register file.
  always_ff @(posedge clk) begin
    if (wr_feature) begin
      feat_r[IAW'(in_data.slot)] <= in_data.value;
    end
    fx_r <= feat_r[cmd.oidx[IAW-1:0]];
  end

  // Hidden store: written from the tanh table, read by the output layer.
  always_ff @(posedge clk) begin
    if (tag5_r.valid) begin
      hmem[tag5_r.unit[HAW-1:0]] <= tanh_q;
    end
    hx_r <= hmem[cmd.oidx[HAW-1:0]];
  end

  // Next tags; a sum finishes only on its last term.
  always_comb begin
    tag1_nxt       = '0;
    tag1_nxt.valid = cmd.issue;
    tag1_nxt.first = cmd.first;
    tag1_nxt.last  = cmd.last;
    tag1_nxt.layer = cmd.layer;
    tag1_nxt.unit  = cmd.unit;
    tag3_nxt       = tag2_r;
    tag3_nxt.valid = tag2_r.valid && tag2_r.last;
    tag5_nxt       = tag4_r;
    tag5_nxt.valid = tag4_r.valid && (tag4_r.layer == LAYER_HIDDEN);
  end

  // Tag pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
      tag5_r <= '0;
    end else begin
      tag1_r <= tag1_nxt;
      tag2_r <= tag1_r;
      tag3_r <= tag3_nxt;
      tag4_r <= tag3_r;
      tag5_r <= tag5_nxt;
    end
  end

  // Multiply stage.
  assign opnd = (tag1_r.layer == LAYER_HIDDEN) ? fx_r : hx_r;

  always_ff @(posedge clk) begin
    prod_r <= opnd * w_r;
  end

  // Accumulate stage; the first term of each sum restarts the accumulator.
  always_ff @(posedge clk) begin
    if (tag2_r.valid) begin
      acc_r <= (tag2_r.first ? '0 : acc_r) + ACC_BITS'(prod_r);
    end
  end

  // Drop the fraction bits (rounding down) and saturate.
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      sat_nxt = VALUE_BITS'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat_nxt = VALUE_BITS'(SAT_LO);
    end else begin
      sat_nxt = VALUE_BITS'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (tag3_r.valid) begin
      sat_r <= sat_nxt;
    end
  end

  // Tanh lookup: top bits of the saturated sum in offset binary.
  assign rom_idx  = {~sat_r[VALUE_BITS-1], sat_r[VALUE_BITS-2:0], {TB{1'b0}}};
  assign rom_addr = rom_idx[VALUE_BITS+TB-1:VALUE_BITS];
  assign rom_en   = tag4_r.valid && (tag4_r.layer == LAYER_HIDDEN);

  mfa_tanh_rom #(
    .TANH_ENTRIES(TANH_ENTRIES)
  ) u_tanh_rom (
    .clk    (clk),
    .rd_en  (rom_en),
    .addr   (rom_addr),
    .rd_data(tanh_q)
  );

  // Running arg-max over the outputs; lowest index wins a tie.
  always_ff @(posedge clk) begin
    if (tag4_r.valid && (tag4_r.layer == LAYER_OUTPUT)) begin
      if ((tag4_r.unit == '0) || (sat_r > best_score_r)) begin
        best_score_r <= sat_r;
        best_index_r <= INDEX_BITS'(tag4_r.unit);
      end
    end
  end

  // Result register, loaded once the pass has finished.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_q_r.best_index <= best_index_r;
      out_q_r.best_score <= best_score_r;
    end
  end

  assign out_data = out_q_r;

endmodule

>>> rtl/mfa_ctrl.sv
module mfa_ctrl #(
  parameter int FEAT_COUNT = 9,
  parameter int HID_COUNT  = 18,
  parameter int OUT_COUNT  = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  mfa_pkg::op_t   in_op,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output mfa_pkg::cmd_t  cmd
);
  import mfa_pkg::*;

  localparam int WGT_TOTAL = FEAT_COUNT * HID_COUNT + HID_COUNT * OUT_COUNT;
  localparam int WAW = (WGT_TOTAL > 1) ? $clog2(WGT_TOTAL) : 1;
  localparam int MAX_UNIT = (HID_COUNT > OUT_COUNT) ? HID_COUNT : OUT_COUNT;
  localparam int MAX_TERM = (FEAT_COUNT > HID_COUNT) ? FEAT_COUNT : HID_COUNT;
  localparam int UW = (MAX_UNIT > 1) ? $clog2(MAX_UNIT) : 1;
  localparam int TW = (MAX_TERM > 1) ? $clog2(MAX_TERM) : 1;
  localparam logic [WAW-1:0] OUT_BASE = WAW'(FEAT_COUNT * HID_COUNT);

  state_t                state_r, state_nxt;
  logic [UW-1:0]         unit_r, unit_nxt;
  logic [TW-1:0]         term_r, term_nxt;
  logic [WAW-1:0]        addr_r, addr_nxt;
  logic [DRAIN_BITS-1:0] drain_r, drain_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  term_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      unit_r      <= '0;
      term_r      <= '0;
      addr_r      <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      unit_r      <= unit_nxt;
      term_r      <= term_nxt;
      addr_r      <= addr_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer: hidden layer input-major sweep, drain, output layer, drain, load.
  always_comb begin
    state_nxt  = state_r;
    unit_nxt   = unit_r;
    term_nxt   = term_r;
    addr_nxt   = addr_r;
    drain_nxt  = drain_r;
    term_end   = 1'b0;
    cmd        = '0;
    cmd.accept = in_valid && in_ready;
    cmd.waddr  = ADDR_BITS'(addr_r);
    cmd.oidx   = TERM_BITS'(term_r);
    cmd.unit   = UNIT_BITS'(unit_r);
    cmd.layer  = LAYER_HIDDEN;

    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && (in_op == OP_FEATURE) && in_last) begin
          state_nxt = ST_HIDDEN;
          unit_nxt  = '0;
          term_nxt  = '0;
          addr_nxt  = '0;
        end
      end

      // Weight i*HID_COUNT+h: step by HID_COUNT along the inputs.
      ST_HIDDEN: begin
        term_end  = (term_r == TW'(FEAT_COUNT - 1));
        cmd.issue = 1'b1;
        cmd.first = (term_r == '0);
        cmd.last  = term_end;
        if (term_end) begin
          term_nxt = '0;
          if (unit_r == UW'(HID_COUNT - 1)) begin
            state_nxt = ST_HDRAIN;
            drain_nxt = '0;
          end else begin
            unit_nxt = unit_r + UW'(1);
            addr_nxt = WAW'(unit_r) + WAW'(1);
          end
        end else begin
          term_nxt = term_r + TW'(1);
          addr_nxt = addr_r + WAW'(HID_COUNT);
        end
      end

      ST_HDRAIN: begin
        drain_nxt = drain_r + DRAIN_BITS'(1);
        if (drain_r == DRAIN_BITS'(DRAIN_CYCLES - 1)) begin
          state_nxt = ST_OUTPUT;
          unit_nxt  = '0;
          term_nxt  = '0;
          addr_nxt  = OUT_BASE;
        end
      end

      // Weight base+h*OUT_COUNT+o: step by OUT_COUNT along the hidden units.
      ST_OUTPUT: begin
        term_end  = (term_r == TW'(HID_COUNT - 1));
        cmd.issue = 1'b1;
        cmd.first = (term_r == '0);
        cmd.last  = term_end;
        cmd.layer = LAYER_OUTPUT;
        if (term_end) begin
          term_nxt = '0;
          if (unit_r == UW'(OUT_COUNT - 1)) begin
            state_nxt = ST_ODRAIN;
            drain_nxt = '0;
          end else begin
            unit_nxt = unit_r + UW'(1);
            addr_nxt = OUT_BASE + WAW'(unit_r) + WAW'(1);
          end
        end else begin
          term_nxt = term_r + TW'(1);
          addr_nxt = addr_r + WAW'(OUT_COUNT);
        end
      end

      ST_ODRAIN: begin
        drain_nxt = drain_r + DRAIN_BITS'(1);
        if (drain_r == DRAIN_BITS'(DRAIN_CYCLES - 1)) begin
          state_nxt = ST_DONE;
        end
      end

      // Wait for the result register to be free.
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid: set by a load, cleared by a transfer.
  assign out_valid_nxt = cmd.load || (out_valid_r && !out_ready);

`ifndef ASSERT_OFF
  a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_FEATURE) && in_last) |=>
      (cmd.issue && cmd.first && (cmd.unit == '0) && (cmd.layer == LAYER_HIDDEN)))
    else $error("pass did not start on the marked feature");

  a_hidden_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.last && (cmd.layer == LAYER_HIDDEN) &&
     (cmd.unit == UNIT_BITS'(HID_COUNT - 1))) |=> !cmd.issue)
    else $error("output layer started before hidden results settled");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not offered");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result offered without a finished pass");
`endif

endmodule

>>> rtl/mlp_forward_argmax.sv
// Two-layer perceptron with tanh hidden units and an arg-max over the outputs.
// Input channel (in_valid/in_ready/in_data): each transfer writes one weight
// (op = weight) or one feature (op = feature). A feature transfer with last
// set stores its value and then starts a pass. While a pass runs, in_ready is
// low; the next transfer can be taken in the same cycle that the result
// register is loaded and out_valid is set. A pass runs one multiply-accumulate
// unit over every weight, one term per cycle: FEAT_COUNT*HID_COUNT hidden
// terms, a pipeline drain, HID_COUNT*OUT_COUNT output terms, another drain,
// then a load.
// Result channel (out_valid/out_ready/out_data): one item per pass with the
// index of the largest output and its score. The result register holds it
// until it is taken; loads are accepted meanwhile, and a following pass runs
// to its end and then waits until the register is free.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid; weight,
// feature and hidden stores keep whatever they held.
module mlp_forward_argmax #(
  parameter int FEAT_COUNT   = 9,
  parameter int HID_COUNT    = 18,
  parameter int OUT_COUNT    = 3,
  parameter int TANH_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfa_pkg::out_item_t  out_data
);
  import mfa_pkg::*;

  cmd_t cmd;

  // Sequencer.
  mfa_ctrl #(
    .FEAT_COUNT(FEAT_COUNT),
    .HID_COUNT (HID_COUNT),
    .OUT_COUNT (OUT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  // Stores, multiply-accumulate pipeline, tanh table and result register.
  mfa_datapath #(
    .FEAT_COUNT  (FEAT_COUNT),
    .HID_COUNT   (HID_COUNT),
    .OUT_COUNT   (OUT_COUNT),
    .TANH_ENTRIES(TANH_ENTRIES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .out_data(out_data)
  );

endmodule

>>> tb/sv/mlp_forward_argmax_tb.sv
module mlp_forward_argmax_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfa_pkg::*;

  localparam int FEAT_COUNT     = 9;
  localparam int HID_COUNT      = 18;
  localparam int OUT_COUNT      = 3;
  localparam int TANH_ENTRIES   = 1024;
  localparam int HIDDEN_WEIGHTS = FEAT_COUNT * HID_COUNT;
  localparam int WGT_TOTAL      = HIDDEN_WEIGHTS + HID_COUNT * OUT_COUNT;
  localparam longint HALF_RANGE = longint'(1) << (VALUE_BITS - 1);
  localparam longint ACC_LIMIT  = longint'(1) << 62;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  localparam int TOTAL_ITEMS  = 800;
  localparam int TAIL_ITEMS   = 120;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_WAIT   = 300;
  localparam int TIMEOUT_NS   = 20_000_000;

  typedef enum int {
    MODE_FULL,
    MODE_EXTREME,
    MODE_SMALL,
    MODE_TOP,
    MODE_BOTTOM
  } value_mode_t;

  // Predicts the winning output of each forward pass and checks the results.
  class argmax_predictor;
    logic signed [VALUE_BITS-1:0] weights [WGT_TOTAL];
    logic signed [VALUE_BITS-1:0] features [FEAT_COUNT];
    logic signed [VALUE_BITS-1:0] hidden [HID_COUNT];
    logic signed [VALUE_BITS-1:0] tanh_lut [TANH_ENTRIES];
    out_item_t pending_winners [$];
    int mismatches;
    int winners_seen;

    function new();
      for (int i = 0; i < TANH_ENTRIES; i++) begin
        tanh_lut[i] = tanh_at_bin(i);
      end
      mismatches   = 0;
      winners_seen = 0;
    endfunction

    // Tanh at the lower edge of a bin, with e^-2a built from (e^-(2a/32))^32.
    function logic signed [VALUE_BITS-1:0] tanh_at_bin(int bin);
      longint lower_x;
      longint unsigned mag_a;
      longint unsigned z;
      longint unsigned term;
      longint unsigned ue;
      longint unsigned num;
      longint unsigned den;
      longint unsigned mag;
      longint e;
      longint signed_mag;
      int k;
      lower_x = ((longint'(bin) << VALUE_BITS) / TANH_ENTRIES) - HALF_RANGE;
      mag_a   = (lower_x < 0) ? u64_t'(-lower_x) : u64_t'(lower_x);
      z       = (mag_a << (31 - FRAC_BITS)) >> 5;
      term    = ONE_Q30;
      e       = longint'(ONE_Q30);
      k       = 1;
      while (k < 64 && term != 0) begin
        term = ((term * z) >> 30) / u64_t'(k);
        if (k % 2 == 1) begin
          e = e - longint'(term);
        end else begin
          e = e + longint'(term);
        end
        k++;
      end
      ue = u64_t'(e);
      for (int i = 0; i < 5; i++) begin
        ue = (ue * ue) >> 30;
      end
      num = ONE_Q30 - ue;
      den = ONE_Q30 + ue;
      mag = ((num << FRAC_BITS) + den / 2) / den;
      signed_mag = (lower_x < 0) ? -longint'(mag) : longint'(mag);
      return signed_mag[VALUE_BITS-1:0];
    endfunction

    // One multiply-accumulate step with the wide accumulator clamp.
    function longint mac_step(longint acc, logic signed [VALUE_BITS-1:0] a,
                              logic signed [VALUE_BITS-1:0] b);
      longint s;
      s = acc + longint'(a) * longint'(b);
      if (s < -ACC_LIMIT) s = -ACC_LIMIT;
      if (s > ACC_LIMIT - 1) s = ACC_LIMIT - 1;
      return s;
    endfunction

    // Drops the fraction bits rounding toward minus infinity, then saturates.
    function logic signed [VALUE_BITS-1:0] settle(longint acc);
      longint shifted;
      shifted = acc >>> FRAC_BITS;
      if (shifted > HALF_RANGE - 1) shifted = HALF_RANGE - 1;
      if (shifted < -HALF_RANGE) shifted = -HALF_RANGE;
      return shifted[VALUE_BITS-1:0];
    endfunction

    // Applies one accepted input transfer; a pass queues its winner.
    function void note_transfer(in_item_t item);
      longint acc;
      logic signed [VALUE_BITS-1:0] s;
      logic signed [VALUE_BITS-1:0] best;
      int best_o;
      int bin;
      out_item_t win;
      if (item.op == OP_WEIGHT) begin
        if (item.slot < WGT_TOTAL) weights[item.slot] = item.value;
        return;
      end
      if (item.slot < FEAT_COUNT) features[item.slot] = item.value;
      if (!item.last) return;

      for (int h = 0; h < HID_COUNT; h++) begin
        acc = 0;
        for (int i = 0; i < FEAT_COUNT; i++) begin
          acc = mac_step(acc, features[i], weights[i * HID_COUNT + h]);
        end
        s   = settle(acc);
        bin = int'(((longint'(s) + HALF_RANGE) * TANH_ENTRIES) >> VALUE_BITS);
        hidden[h] = tanh_lut[bin];
      end

      best   = '0;
      best_o = 0;
      for (int o = 0; o < OUT_COUNT; o++) begin
        acc = 0;
        for (int h = 0; h < HID_COUNT; h++) begin
          acc = mac_step(acc, hidden[h], weights[HIDDEN_WEIGHTS + h * OUT_COUNT + o]);
        end
        s = settle(acc);
        if (o == 0 || s > best) begin
          best   = s;
          best_o = o;
        end
      end
      win.best_index = best_o[INDEX_BITS-1:0];
      win.best_score = best;
      pending_winners = {pending_winners, win};
    endfunction

    // Compares one accepted result with the oldest predicted winner.
    function void check_winner(out_item_t got);
      out_item_t want;
      winners_seen++;
      if (pending_winners.size() == 0) begin
        $error("unexpected result: best_index=%0d best_score=%0d",
               got.best_index, $signed(got.best_score));
        mismatches++;
        return;
      end
      want = pending_winners.pop_front();
      if (got.best_index !== want.best_index) begin
        $error("best_index mismatch: expected %0d, actual %0d",
               want.best_index, got.best_index);
        mismatches++;
      end
      if (got.best_score !== want.best_score) begin
        $error("best_score mismatch: expected %0d, actual %0d",
               $signed(want.best_score), $signed(got.best_score));
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending_winners.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  argmax_predictor forecast = new();

  bit idle_on;
  bit calm_tail;
  int items_sent;

  mlp_forward_argmax #(
    .FEAT_COUNT  (FEAT_COUNT),
    .HID_COUNT   (HID_COUNT),
    .OUT_COUNT   (OUT_COUNT),
    .TANH_ENTRIES(TANH_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Every accepted result transfer goes to the checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      forecast.check_winner(out_data);
    end
  end

  // Receiver: short random stalls, plus long hold-offs that back up the block.
  initial begin : receiver
    int quiet;
    int holds_done;
    int cycle_count;
    bit rx_idle_on;
    out_ready   = 1'b0;
    quiet       = 0;
    holds_done  = 0;
    cycle_count = 0;
    rx_idle_on  = 1'b1;
    wait (rst_n == 1'b1);
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count % 50 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      if (holds_done < 2 && !calm_tail && forecast.winners_seen >= 4 + 30 * holds_done) begin
        holds_done++;
        quiet = HOLD_CYCLES;
      end
      if (quiet == 0 && rx_idle_on && !calm_tail && $urandom_range(0, 4) == 0) begin
        quiet = $urandom_range(1, 3);
      end
      if (quiet > 0) begin
        out_ready <= 1'b0;
        quiet--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_item(op_t op, int slot,
                                         logic signed [VALUE_BITS-1:0] value, bit last);
    in_item_t item;
    item.op    = op;
    item.slot  = slot[SLOT_BITS-1:0];
    item.value = value;
    item.last  = last;
    return item;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value(value_mode_t mode);
    logic [VALUE_BITS-1:0] raw;
    int small_v;
    case (mode)
      MODE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       raw = 16'h8000;
          1:       raw = 16'h7fff;
          2:       raw = 16'h0000;
          3:       raw = 16'hffff;
          default: raw = 16'h0001;
        endcase
      end
      MODE_SMALL: begin
        small_v = int'($urandom_range(0, 4095)) - 2048;
        raw = small_v[VALUE_BITS-1:0];
      end
      MODE_TOP:    raw = 16'h7fff;
      MODE_BOTTOM: raw = 16'h8000;
      default:     raw = VALUE_BITS'($urandom());
    endcase
    return raw;
  endfunction

  // Offers one item and holds it until the transfer completes.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    if (idle_on && !calm_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    forecast.note_transfer(item);
    items_sent++;
    @(negedge clk);
  endtask

  // Writes every weight and feature, then starts a pass.
  task automatic load_network(input value_mode_t mode);
    for (int w = 0; w < WGT_TOTAL; w++) begin
      send_item(make_item(OP_WEIGHT, w, pick_value(mode), 1'b0));
    end
    for (int f = 0; f < FEAT_COUNT; f++) begin
      send_item(make_item(OP_FEATURE, f, pick_value(mode), f == FEAT_COUNT - 1));
    end
  endtask

  // Feature write with last; now and then with a slot beyond the register file.
  task automatic start_pass(input value_mode_t mode);
    int slot;
    if ($urandom_range(0, 7) == 0) begin
      slot = $urandom_range(FEAT_COUNT, 255);
    end else begin
      slot = $urandom_range(0, FEAT_COUNT - 1);
    end
    send_item(make_item(OP_FEATURE, slot, pick_value(mode), 1'b1));
  endtask

  // A few weight and feature updates followed by a pass.
  task automatic tweak_and_run();
    value_mode_t mode;
    int n_weights;
    int n_features;
    mode       = value_mode_t'($urandom_range(0, 4));
    n_weights  = $urandom_range(0, 12);
    n_features = $urandom_range(0, 4);
    repeat (n_weights) begin
      send_item(make_item(OP_WEIGHT, $urandom_range(0, WGT_TOTAL - 1),
                          pick_value(mode), $urandom_range(0, 1)));
    end
    repeat (n_features) begin
      send_item(make_item(OP_FEATURE, $urandom_range(0, FEAT_COUNT - 1),
                          pick_value(mode), 1'b0));
    end
    start_pass(mode);
  endtask

  // Output weights with equal columns (column 0 negated at times), so that scores tie.
  task automatic tie_outputs();
    logic signed [VALUE_BITS-1:0] v;
    bit split;
    split = $urandom_range(0, 1);
    for (int h = 0; h < HID_COUNT; h++) begin
      v = pick_value(MODE_SMALL);
      for (int o = 0; o < OUT_COUNT; o++) begin
        send_item(make_item(OP_WEIGHT, HIDDEN_WEIGHTS + h * OUT_COUNT + o,
                            (split && o == 0) ? -v : v, 1'b0));
      end
    end
    start_pass(MODE_FULL);
  endtask

  // Writes that the block ignores, and items with random fields.
  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: send_item(make_item(OP_WEIGHT, $urandom_range(WGT_TOTAL, 255),
                               pick_value(MODE_FULL), $urandom_range(0, 1)));
        1: send_item(make_item(OP_FEATURE, $urandom_range(FEAT_COUNT, 255),
                               pick_value(MODE_FULL), 1'b0));
        default: send_item(make_item(op_t'($urandom_range(0, 1)), $urandom_range(0, 255),
                                     pick_value(MODE_FULL), $urandom_range(0, 1)));
      endcase
    end
  endtask

  // Main sequence: reset, full load, directed cases, random traffic, drain.
  initial begin : stimulus
    int kind;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    idle_on    = 1'b1;
    calm_tail  = 1'b0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every store entry is written before the first pass reads it.
    load_network(MODE_FULL);

    // Directed cases: field extremes, ignored writes and the ways a pass starts.
    send_item(make_item(OP_WEIGHT, 0, 16'sh8000, 1'b0));
    send_item(make_item(OP_WEIGHT, WGT_TOTAL - 1, 16'sh7fff, 1'b0));
    send_item(make_item(OP_WEIGHT, HIDDEN_WEIGHTS - 1, 16'sh7fff, 1'b0));
    send_item(make_item(OP_WEIGHT, HIDDEN_WEIGHTS, 16'sh8000, 1'b0));
    send_item(make_item(OP_WEIGHT, 255, 16'sh7fff, 1'b0));
    send_item(make_item(OP_WEIGHT, WGT_TOTAL, 16'sh8000, 1'b1));
    send_item(make_item(OP_WEIGHT, 100, 16'sh0000, 1'b1));
    send_item(make_item(OP_FEATURE, 0, 16'sh7fff, 1'b0));
    send_item(make_item(OP_FEATURE, FEAT_COUNT - 1, 16'sh8000, 1'b0));
    send_item(make_item(OP_FEATURE, 4, 16'sh0000, 1'b1));
    send_item(make_item(OP_FEATURE, 255, 16'sh3039, 1'b1));
    send_item(make_item(OP_FEATURE, FEAT_COUNT, 16'shffff, 1'b0));
    send_item(make_item(OP_FEATURE, 3, 16'shffff, 1'b1));
    send_item(make_item(OP_FEATURE, 1, 16'sh0001, 1'b1));
    send_item(make_item(OP_FEATURE, 0, 16'sh8000, 1'b1));

    // Random traffic: mostly updates followed by a pass, some noise.
    while (items_sent < TOTAL_ITEMS) begin
      calm_tail = (items_sent >= TOTAL_ITEMS - TAIL_ITEMS);
      idle_on   = !calm_tail && ($urandom_range(0, 3) != 0);
      kind      = $urandom_range(0, 99);
      if (kind < 3) begin
        load_network(value_mode_t'($urandom_range(0, 4)));
      end else if (kind < 8) begin
        tie_outputs();
      end else if (kind < 20) begin
        noise_burst();
      end else begin
        tweak_and_run();
      end
    end
    in_valid <= 1'b0;

    // Wait for the outstanding results, then watch for strays.
    while (forecast.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (forecast.mismatches == 0 && forecast.pending_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mfa_pkg.sv
rtl/mfa_tanh_rom.sv
rtl/mfa_datapath.sv
rtl/mfa_ctrl.sv
rtl/mlp_forward_argmax.sv
tb/sv/mlp_forward_argmax_tb.sv
